/* hw/rtl/i2crb_pkg.sv */
// ----------------------------------------------------------------------------
// i2crb_pkg
// Types, constants and helpers of the I2C slave register bank with pulse capture.
// ----------------------------------------------------------------------------
`default_nettype none

package i2crb_pkg;

    localparam int BANK_DEPTH = 64;
    localparam int CHANNELS   = 3;

    localparam int AW    = $clog2(BANK_DEPTH);
    localparam int PTR_W = $clog2(BANK_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_RELEASED  = 3'd0,
        PH_ADDRESS   = 3'd1,
        PH_ACKRX     = 3'd2,
        PH_BYTERX    = 3'd3,
        PH_ACKTX     = 3'd4,
        PH_BYTETX    = 3'd5,
        PH_MASTERACK = 3'd6
    } t_phase;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_SHIFT = 2'd1;
    localparam logic [1:0] MODE_PIN   = 2'd2;

    localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
    localparam logic [1:0] REG_PULSE_MIN  = 2'd1;
    localparam logic [1:0] REG_PULSE_MAX  = 2'd2;

    localparam logic [6:0]  RST_SLAVE_ADDR = 7'h20;
    localparam logic [15:0] RST_PULSE_MIN  = 16'd700;
    localparam logic [15:0] RST_PULSE_MAX  = 16'd2300;

    // Bank bytes kept in flops: pin copy, then low/high width byte per channel.
    localparam int SPEC_N   = 7;
    localparam int SPEC_PIN = 0;
    localparam logic [7:0] SPEC_ADDR [SPEC_N] = '{
        8'h0f, 8'h10, 8'h11, 8'h20, 8'h21, 8'h30, 8'h31
    };

    // Bit of the pin copy byte that each channel lands on.
    localparam int PIN_POS [3] = '{1, 3, 4};

    typedef struct packed {
        t_phase      phase;
        logic        drv;
        logic        single;
        logic        load;
        logic [7:0]  txb;
    } t_bus_res;

    function automatic logic [7:0] bank_reset_byte(input logic [AW-1:0] addr);
        logic [7:0] val;
        val = 8'h00;
        if (32'(addr) == 0) val = 8'hC0;
        if (32'(addr) == 1) val = 8'hFF;
        if (32'(addr) == 2) val = 8'hEE;
        return val;
    endfunction

    function automatic logic cap_fits(input int ch);
        return (16 * (ch + 1) + 1) < BANK_DEPTH;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2crb_ram.sv */
// ----------------------------------------------------------------------------
// i2crb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2crb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

/* hw/rtl/i2c_slave_register_bank_pulse_capture_unit.sv */
// ----------------------------------------------------------------------------
// i2c_slave_register_bank_pulse_capture_unit
// I2C slave byte-level engine with register bank and three-channel pulse timer.
// ----------------------------------------------------------------------------
// Items (start, completed shift, pin sample) enter an input register and are
// processed from it in one pass into the output register. A new item can be
// accepted every cycle while the output register is free or being emptied.
// Start and shift items give one result; a pin sample gives one per stored
// pulse width (one to three, else one result), which leave the output register
// one per cycle while the receiver is ready. The bank RAM is read ahead at the
// next pointer so read data is ready when the next item arrives. Bank entries
// reset through per-entry valid bits; no clearing pass is needed after reset.
`default_nettype none

module i2c_slave_register_bank_pulse_capture_unit
    import i2crb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: shift_data[7:0], pin_levels[10:8], time_us[42:11], zero pad
    input  wire logic [47:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: bus_phase[2:0], sda_drive[3], single_bit_next[4], tx_load[5],
    //        tx_byte[13:6], capture_valid[14], capture_channel[16:15],
    //        capture_width[32:17], zero pad
    output logic      [39:0] m_axis_tdata,
    output logic             m_axis_tlast
);

    // ---------------- configuration ----------------
    logic [6:0]  r_slave_addr;
    logic [15:0] r_pulse_min;
    logic [15:0] r_pulse_max;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= RST_SLAVE_ADDR;
            r_pulse_min  <= RST_PULSE_MIN;
            r_pulse_max  <= RST_PULSE_MAX;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_SLAVE_ADDR: r_slave_addr <= pwdata[6:0];
                REG_PULSE_MIN:  r_pulse_min  <= pwdata[15:0];
                REG_PULSE_MAX:  r_pulse_max  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SLAVE_ADDR: prdata = {25'd0, r_slave_addr};
            REG_PULSE_MIN:  prdata = {16'd0, r_pulse_min};
            REG_PULSE_MAX:  prdata = {16'd0, r_pulse_max};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    logic                r_in_valid;
    logic [1:0]          r_in_mode;
    logic [7:0]          r_in_data;
    logic [CHANNELS-1:0] r_in_pins;
    logic [31:0]         r_in_time;

    logic in_fire;
    logic in_adv;
    logic res_free;
    logic out_fire;
    logic out_last;

    assign in_adv        = r_in_valid && res_free;
    assign s_axis_tready = !r_in_valid || in_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (in_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_mode <= s_axis_tuser;
            r_in_data <= s_axis_tdata[7:0];
            r_in_pins <= s_axis_tdata[8 +: CHANNELS];
            r_in_time <= s_axis_tdata[42:11];
        end
    end

    // ---------------- state ----------------
    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_pending;
    logic                n_pending;
    logic [PTR_W-1:0]    r_ptr;
    logic [PTR_W-1:0]    n_ptr;
    logic [CHANNELS-1:0] r_pins_prev;
    logic [31:0]         r_rise [CHANNELS];
    logic [31:0]         n_rise [CHANNELS];
    logic [7:0]          r_spec [SPEC_N];
    logic [BANK_DEPTH-1:0] r_vld;
    logic                r_rd_ok;

    // ---------------- bus FSM: next state ----------------
    logic is_shift;
    logic addr_match;

    assign is_shift   = (r_in_mode == MODE_SHIFT);
    assign addr_match = (r_in_data[7:1] == r_slave_addr);

    always_comb begin
        n_phase = r_phase;
        if (r_in_mode == MODE_START) begin
            n_phase = PH_ADDRESS;
        end else if (is_shift) begin
            unique case (r_phase)
                PH_ADDRESS: begin
                    if (!addr_match)      n_phase = PH_RELEASED;
                    else if (r_in_data[0]) n_phase = PH_ACKTX;
                    else                   n_phase = PH_ACKRX;
                end
                PH_ACKRX:     n_phase = PH_BYTERX;
                PH_BYTERX:    n_phase = PH_ACKRX;
                PH_ACKTX:     n_phase = PH_BYTETX;
                PH_BYTETX:    n_phase = PH_MASTERACK;
                PH_MASTERACK: n_phase = r_in_data[0] ? PH_ADDRESS : PH_BYTETX;
                default:      n_phase = r_phase;
            endcase
        end
    end

    // ---------------- bus FSM: outputs ----------------
    logic bo_drv, bo_single, bo_load, bo_arm, bo_recv;

    always_comb begin
        bo_drv    = 1'b0;
        bo_single = 1'b0;
        bo_load   = 1'b0;
        bo_arm    = 1'b0;
        bo_recv   = 1'b0;
        if (is_shift) begin
            unique case (r_phase)
                PH_ADDRESS: begin
                    if (addr_match) begin
                        bo_arm    = 1'b1;
                        bo_drv    = 1'b1;
                        bo_single = 1'b1;
                    end
                end
                PH_BYTERX: begin
                    bo_recv   = 1'b1;
                    bo_drv    = 1'b1;
                    bo_single = 1'b1;
                end
                PH_ACKTX: begin
                    bo_load = 1'b1;
                    bo_drv  = 1'b1;
                end
                PH_MASTERACK: begin
                    if (!r_in_data[0]) begin
                        bo_load = 1'b1;
                        bo_drv  = 1'b1;
                    end
                end
                PH_BYTETX: bo_single = 1'b1;
                default: ;
            endcase
        end
    end

    // ---------------- bank access ----------------
    logic            ptr_ok;
    logic [AW-1:0]   ptr_a;
    logic [7:0]      ram_q;
    logic [7:0]      rd_byte;
    logic            spec_hit;
    logic [2:0]      spec_idx;
    logic            bank_we;
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic            nptr_ok;

    assign ptr_ok = (32'(r_ptr) < BANK_DEPTH);
    assign ptr_a  = ptr_ok ? r_ptr[AW-1:0] : '0;

    always_comb begin
        spec_hit = 1'b0;
        spec_idx = '0;
        for (int k = 0; k < SPEC_N; k++) begin
            if (32'(r_ptr) == 32'(SPEC_ADDR[k])) begin
                spec_hit = 1'b1;
                spec_idx = 3'(k);
            end
        end
    end

    always_comb begin
        if (!ptr_ok)       rd_byte = 8'h00;
        else if (spec_hit) rd_byte = r_spec[spec_idx];
        else if (r_rd_ok)  rd_byte = ram_q;
        else               rd_byte = bank_reset_byte(ptr_a);
    end

    always_comb begin
        n_ptr     = r_ptr;
        n_pending = r_pending;
        bank_we   = 1'b0;
        if (bo_arm) begin
            n_pending = 1'b1;
        end
        if (bo_recv) begin
            if (r_pending) begin
                n_pending = 1'b0;
                if (32'(r_in_data) >= BANK_DEPTH) n_ptr = PTR_W'(BANK_DEPTH);
                else                              n_ptr = PTR_W'(r_in_data);
            end else if (ptr_ok) begin
                bank_we = 1'b1;
                n_ptr   = r_ptr + PTR_W'(1);
            end
        end
        if (bo_load && ptr_ok) begin
            n_ptr = r_ptr + PTR_W'(1);
        end
    end

    assign ram_we = in_adv && bank_we && !spec_hit;

    // Read ahead at the pointer the next item will see.
    logic [PTR_W-1:0] rd_ptr;
    assign rd_ptr    = in_adv ? n_ptr : r_ptr;
    assign nptr_ok   = (32'(rd_ptr) < BANK_DEPTH);
    assign ram_raddr = nptr_ok ? rd_ptr[AW-1:0] : '0;

    i2crb_ram #(
        .WIDTH(8),
        .DEPTH(BANK_DEPTH)
    ) u_bank (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ptr_a),
        .i_wdata(r_in_data),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    // ---------------- pulse capture ----------------
    logic                pin_chg;
    logic [7:0]          pin_copy;
    logic [31:0]         width [CHANNELS];
    logic [CHANNELS-1:0] cap_store;

    assign pin_chg = (r_in_mode == MODE_PIN) && (r_in_pins != r_pins_prev);

    always_comb begin
        pin_copy = 8'h00;
        for (int i = 0; i < CHANNELS; i++) begin
            pin_copy[PIN_POS[i]] = r_in_pins[i];
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            width[i]     = r_in_time - r_rise[i];
            n_rise[i]    = r_rise[i];
            cap_store[i] = 1'b0;
            if (pin_chg && (r_in_pins[i] != r_pins_prev[i])) begin
                if (r_in_pins[i]) begin
                    n_rise[i] = r_in_time;
                end else begin
                    // high time also replaces the stored edge time
                    n_rise[i]    = width[i];
                    cap_store[i] = (width[i] > {16'd0, r_pulse_min}) &&
                                   (width[i] < {16'd0, r_pulse_max}) && cap_fits(i);
                end
            end
        end
    end

    // ---------------- state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RELEASED;
            r_pending   <= 1'b0;
            r_ptr       <= '0;
            r_pins_prev <= '0;
            r_vld       <= '0;
            r_rd_ok     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) r_rise[i] <= 32'd0;
            for (int k = 0; k < SPEC_N; k++)   r_spec[k] <= 8'h00;
        end else begin
            r_rd_ok <= r_vld[ram_raddr];
            if (in_adv) begin
                r_phase   <= n_phase;
                r_pending <= n_pending;
                r_ptr     <= n_ptr;
                if (ram_we) begin
                    r_vld[ptr_a] <= 1'b1;
                end
                if (bank_we && spec_hit) begin
                    r_spec[spec_idx] <= r_in_data;
                end
                if (pin_chg) begin
                    r_pins_prev <= r_in_pins;
                    if (32'(SPEC_ADDR[SPEC_PIN]) < BANK_DEPTH) begin
                        r_spec[SPEC_PIN] <= pin_copy;
                    end
                end
                for (int i = 0; i < CHANNELS; i++) begin
                    r_rise[i] <= n_rise[i];
                    if (cap_store[i]) begin
                        r_spec[1 + 2 * i] <= width[i][7:0];
                        r_spec[2 + 2 * i] <= width[i][15:8];
                    end
                end
            end
        end
    end

    // ---------------- result register ----------------
    logic                r_res_valid;
    t_bus_res            r_res;
    t_bus_res            n_res;
    logic [CHANNELS-1:0] r_cap_mask;
    logic [15:0]         r_cap_w [CHANNELS];

    always_comb begin
        n_res.phase  = n_phase;
        n_res.drv    = bo_drv;
        n_res.single = bo_single;
        n_res.load   = bo_load;
        n_res.txb    = bo_load ? rd_byte : 8'h00;
    end

    logic                has_cap;
    logic [1:0]          cur_ch;
    logic [CHANNELS-1:0] rest_mask;

    assign has_cap = |r_cap_mask;

    always_comb begin
        cur_ch = 2'd0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (r_cap_mask[i]) cur_ch = 2'(i);
        end
        rest_mask = r_cap_mask;
        rest_mask[cur_ch] = 1'b0;
    end

    assign out_last = !has_cap || (rest_mask == '0);
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign res_free = !r_res_valid || (out_fire && out_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_cap_mask  <= '0;
        end else if (in_adv) begin
            r_res_valid <= 1'b1;
            r_cap_mask  <= cap_store;
        end else if (out_fire) begin
            if (out_last) r_res_valid <= 1'b0;
            else          r_cap_mask  <= rest_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_res <= n_res;
            for (int i = 0; i < CHANNELS; i++) r_cap_w[i] <= width[i][15:0];
        end
    end

    logic [1:0]  o_ch;
    logic [15:0] o_w;

    assign o_ch = has_cap ? cur_ch : 2'd0;
    assign o_w  = has_cap ? r_cap_w[cur_ch] : 16'd0;

    assign m_axis_tvalid = r_res_valid;
    assign m_axis_tlast  = out_last;
    assign m_axis_tdata  = {7'd0, o_w, o_ch, has_cap, r_res.txb, r_res.load,
                            r_res.single, r_res.drv, r_res.phase};

    // ---------------- assertions ----------------
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ptr) <= BANK_DEPTH)
        else $error("bank pointer beyond saturation value");

    a_ram_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ptr_a != ram_raddr))
        else $error("bank write and read-ahead hit the same entry");

    a_load_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.load) |-> (r_res.drv && !has_cap))
        else $error("tx load without SDA drive or with capture data");

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv |=> r_res_valid)
        else $error("processed item left no result");

    a_more_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && !out_last) |=> (r_res_valid && has_cap))
        else $error("pending capture results lost");

endmodule

`default_nettype wire

/* tb/sv/i2c_slave_register_bank_pulse_capture_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_slave_register_bank_pulse_capture_unit_test
// Self-checking bench for the I2C register bank slave with pulse capture.
// ----------------------------------------------------------------------------
// Items are bus events (start, completed shift) and pin samples. A scoreboard
// class tracks the bus state, the 64-byte bank, the pointer and the pulse
// timers, and queues the results each accepted item should produce. Every
// result leaving the block is compared field by field with the oldest one.
// A directed run covers the corner cases, then several register settings get
// well-formed write/read transactions and pulse trains mixed with noise, under
// random sender gaps and receiver stalls.
`default_nettype none

module i2c_slave_register_bank_pulse_capture_unit_test
    import i2crb_pkg::*;
();

    localparam int         LIMIT         = 200000;
    localparam logic [1:0] MODE_SPARE    = 2'd3;
    localparam logic [7:0] PIN_COPY_ADDR = 8'h0f;
    localparam logic       I2C_WR        = 1'b0;
    localparam logic       I2C_RD        = 1'b1;
    localparam logic       NACK          = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  shifted;
        logic [2:0]  levels;
        logic [31:0] stamp;
    } t_bus_item;

    typedef struct packed {
        t_phase      phase;
        logic        drv;
        logic        single;
        logic        load;
        logic [7:0]  txb;
        logic        cv;
        logic [1:0]  ch;
        logic [15:0] width;
        logic        last;
    } t_bank_result;

    class bank_scoreboard;
        logic [6:0]   own_addr;
        logic [15:0]  min_us;
        logic [15:0]  max_us;
        t_phase       bus_state;
        logic         ptr_armed;
        logic [6:0]   ptr;
        logic [7:0]   regs [BANK_DEPTH];
        logic [2:0]   pins_last;
        logic [31:0]  rise_at [3];
        t_bank_result due_results [$];
        int           err_count;

        function new();
            own_addr  = RST_SLAVE_ADDR;
            min_us    = RST_PULSE_MIN;
            max_us    = RST_PULSE_MAX;
            bus_state = PH_RELEASED;
            ptr_armed = 1'b0;
            ptr       = '0;
            foreach (regs[i]) regs[i] = 8'h00;
            regs[0]   = 8'hC0;
            regs[1]   = 8'hFF;
            regs[2]   = 8'hEE;
            pins_last = '0;
            foreach (rise_at[i]) rise_at[i] = '0;
            err_count = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_SLAVE_ADDR: own_addr = value[6:0];
                REG_PULSE_MIN:  min_us   = value[15:0];
                REG_PULSE_MAX:  max_us   = value[15:0];
                default: ;
            endcase
        endfunction

        // read at the pointer; a saturated pointer reads 0 and stays put
        function logic [7:0] fetch_byte();
            logic [7:0] val;
            val = 8'h00;
            if (ptr < BANK_DEPTH) begin
                val = regs[ptr];
                ptr++;
            end
            return val;
        endfunction

        function void store_byte(logic [7:0] b);
            if (ptr_armed) begin
                ptr       = (b >= BANK_DEPTH) ? 7'(BANK_DEPTH) : b[6:0];
                ptr_armed = 1'b0;
            end else if (ptr < BANK_DEPTH) begin
                regs[ptr] = b;
                ptr++;
            end
        endfunction

        function void note_item(t_bus_item it);
            t_bank_result r;
            t_bank_result cap;
            t_bank_result caps [$];
            logic [7:0]   copy;
            logic [31:0]  width;
            int           base;
            r = '0;
            r.last = 1'b1;
            case (it.mode)
                MODE_START: bus_state = PH_ADDRESS;
                MODE_SHIFT: begin
                    case (bus_state)
                        PH_ADDRESS: begin
                            if (it.shifted[7:1] != own_addr) begin
                                bus_state = PH_RELEASED;
                            end else begin
                                ptr_armed = 1'b1;
                                r.drv     = 1'b1;
                                r.single  = 1'b1;
                                bus_state = it.shifted[0] ? PH_ACKTX : PH_ACKRX;
                            end
                        end
                        PH_ACKRX: bus_state = PH_BYTERX;
                        PH_BYTERX: begin
                            store_byte(it.shifted);
                            r.drv     = 1'b1;
                            r.single  = 1'b1;
                            bus_state = PH_ACKRX;
                        end
                        PH_ACKTX: begin
                            r.txb     = fetch_byte();
                            r.load    = 1'b1;
                            r.drv     = 1'b1;
                            bus_state = PH_BYTETX;
                        end
                        PH_MASTERACK: begin
                            if (it.shifted[0] == NACK) begin
                                bus_state = PH_ADDRESS;
                            end else begin
                                r.txb     = fetch_byte();
                                r.load    = 1'b1;
                                r.drv     = 1'b1;
                                bus_state = PH_BYTETX;
                            end
                        end
                        PH_BYTETX: begin
                            r.single  = 1'b1;
                            bus_state = PH_MASTERACK;
                        end
                        default: ;
                    endcase
                end
                MODE_PIN: begin
                    if (it.levels != pins_last) begin
                        copy = '0;
                        for (int c = 0; c < CHANNELS; c++)
                            copy[PIN_POS[c]] = it.levels[c];
                        regs[PIN_COPY_ADDR] = copy;
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (it.levels[c] == pins_last[c]) continue;
                            if (it.levels[c]) begin
                                rise_at[c] = it.stamp;
                            end else begin
                                // timer slot keeps the measured width afterwards
                                width      = it.stamp - rise_at[c];
                                rise_at[c] = width;
                                base       = 16 * (c + 1);
                                if (width > min_us && width < max_us &&
                                        base + 1 < BANK_DEPTH) begin
                                    regs[base]     = width[7:0];
                                    regs[base + 1] = width[15:8];
                                    cap       = '0;
                                    cap.phase = bus_state;
                                    cap.cv    = 1'b1;
                                    cap.ch    = 2'(c);
                                    cap.width = width[15:0];
                                    caps.push_back(cap);
                                end
                            end
                        end
                        pins_last = it.levels;
                    end
                end
                default: ;
            endcase
            r.phase = bus_state;
            if (caps.size() == 0) begin
                due_results.push_back(r);
            end else begin
                caps[caps.size() - 1].last = 1'b1;
                foreach (caps[k]) due_results.push_back(caps[k]);
            end
        endfunction

        function void match(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                err_count++;
            end
        endfunction

        function void check_result(logic [39:0] data, logic tlast);
            t_bank_result want;
            if (due_results.size() == 0) begin
                $error("result with nothing expected: tdata 0x%0h tlast %0b", data, tlast);
                err_count++;
                return;
            end
            want = due_results.pop_front();
            match("bus_phase",       32'(want.phase),  32'(data[2:0]));
            match("sda_drive",       32'(want.drv),    32'(data[3]));
            match("single_bit_next", 32'(want.single), 32'(data[4]));
            match("tx_load",         32'(want.load),   32'(data[5]));
            match("tx_byte",         32'(want.txb),    32'(data[13:6]));
            match("capture_valid",   32'(want.cv),     32'(data[14]));
            match("capture_channel", 32'(want.ch),     32'(data[16:15]));
            match("capture_width",   32'(want.width),  32'(data[32:17]));
            match("last",            32'(want.last),   32'(tlast));
        endfunction
    endclass

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: shift_data[7:0], pin_levels[10:8], time_us[42:11], zero pad
    logic [47:0] s_axis_tdata  = '0;
    // tuser: mode[1:0]
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: bus_phase[2:0], sda_drive[3], single_bit_next[4], tx_load[5],
    //        tx_byte[13:6], capture_valid[14], capture_channel[16:15],
    //        capture_width[32:17], zero pad
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    bank_scoreboard sb = new();

    int          cycles     = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    logic [2:0]  pins_now   = '0;
    logic [31:0] us_now     = '0;

    i2c_slave_register_bank_pulse_capture_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("i2c_slave_register_bank_pulse_capture_unit_test: done, errors");
            $finish;
        end
    end

    // receiver: always ready, coin flips, mostly stalled, periodic stalls
    always @(posedge i_clk) begin
        case (cycles[10:9])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_axis_tready <= (cycles[1:0] == 2'd0);
            default: m_axis_tready <= (cycles % 7) < 5;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] shifted,
                             input logic [2:0] levels, input logic [31:0] stamp);
        t_bus_item it;
        int        gap;
        it = '{mode, shifted, levels, stamp};
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {5'b0, stamp, levels, shifted};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
        items_sent++;
        burst_left--;
    endtask

    // bus event; pin and time fields are don't-care, so randomize them
    task automatic bus_event(input logic [1:0] mode, input logic [7:0] shifted);
        send_item(mode, shifted, 3'($urandom_range(0, 7)), $urandom());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.due_results.size() != 0);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] addr, input logic [15:0] lo,
                             input logic [15:0] hi);
        apb_write(REG_SLAVE_ADDR, 32'(addr));
        apb_write(REG_PULSE_MIN, 32'(lo));
        apb_write(REG_PULSE_MAX, 32'(hi));
    endtask

    // pointer byte, then data bytes, each followed by its ack slot
    task automatic write_txn();
        int         n;
        logic [7:0] where;
        n = $urandom_range(0, 5);
        where = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, BANK_DEPTH - 1));
        bus_event(MODE_START, 8'($urandom));
        bus_event(MODE_SHIFT, {sb.own_addr, I2C_WR});
        bus_event(MODE_SHIFT, 8'($urandom));
        bus_event(MODE_SHIFT, where);
        bus_event(MODE_SHIFT, 8'($urandom));
        repeat (n) begin
            bus_event(MODE_SHIFT, 8'($urandom));
            bus_event(MODE_SHIFT, 8'($urandom));
        end
    endtask

    task automatic read_txn();
        int         n;
        logic       cut;
        logic [7:0] ack;
        n   = $urandom_range(1, 6);
        cut = ($urandom_range(0, 9) == 0);
        bus_event(MODE_START, 8'($urandom));
        bus_event(MODE_SHIFT, {sb.own_addr, I2C_RD});
        bus_event(MODE_SHIFT, 8'($urandom));
        for (int k = 0; k < n; k++) begin
            bus_event(MODE_SHIFT, 8'($urandom));
            if (cut && k == n - 1) break;
            ack = 8'($urandom);
            ack[0] = (k == n - 1) ? NACK : ~NACK;
            bus_event(MODE_SHIFT, ack);
        end
    endtask

    task automatic pin_event();
        int c;
        if ($urandom_range(0, 9) == 0) begin
            pins_now = 3'($urandom_range(0, 7));
        end else begin
            c = $urandom_range(0, 2);
            pins_now[c] = ~pins_now[c];
        end
        if ($urandom_range(0, 19) == 0)
            us_now = $urandom();
        else
            us_now += $urandom_range(1, 32'(sb.max_us) + 600);
        send_item(MODE_PIN, 8'($urandom), pins_now, us_now);
    endtask

    task automatic traffic(input int n);
        int   target;
        int   half;
        int   pick;
        logic paused;
        target = items_sent + n;
        half   = items_sent + n / 2;
        paused = 1'b0;
        while (items_sent < target) begin
            if (!paused && items_sent >= half) begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
                write_txn();
            else if (pick < 58)
                read_txn();
            else if (pick < 90)
                pin_event();
            else if (pick < 95)
                send_item(2'($urandom_range(0, 3)), 8'($urandom),
                          3'($urandom_range(0, 7)), $urandom());
            else begin
                bus_event(MODE_START, 8'($urandom));
                bus_event(MODE_SHIFT, 8'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pins equal to the previous sample, shift while released
        send_item(MODE_PIN, 8'h00, 3'b000, 32'h0);
        bus_event(MODE_SHIFT, {RST_SLAVE_ADDR, I2C_WR});
        // wrong address
        bus_event(MODE_START, 8'h00);
        bus_event(MODE_SHIFT, 8'hFF);
        // write with an out-of-range pointer, then a write that is dropped
        bus_event(MODE_START, 8'h00);
        bus_event(MODE_SHIFT, {RST_SLAVE_ADDR, I2C_WR});
        bus_event(MODE_SHIFT, 8'h00);
        bus_event(MODE_SHIFT, 8'hFF);
        bus_event(MODE_SHIFT, 8'h01);
        bus_event(MODE_SHIFT, 8'hA5);
        bus_event(MODE_SHIFT, 8'h00);
        // repeated start, read at the saturated pointer, ack then NACK
        bus_event(MODE_START, 8'hFF);
        bus_event(MODE_SHIFT, {RST_SLAVE_ADDR, I2C_RD});
        bus_event(MODE_SHIFT, 8'h00);
        bus_event(MODE_SHIFT, 8'h00);
        bus_event(MODE_SHIFT, 8'hFE);
        bus_event(MODE_SHIFT, 8'h00);
        bus_event(MODE_SHIFT, 8'h01);
        // all three channels at once, timestamp wrapping past zero
        send_item(MODE_PIN, 8'h00, 3'b111, 32'hFFFF_FF00);
        send_item(MODE_PIN, 8'hFF, 3'b000, 32'h0000_02E8);
        // widths at the limits are rejected, just above the minimum is kept
        send_item(MODE_PIN, 8'h00, 3'b010, 32'd0);
        send_item(MODE_PIN, 8'h00, 3'b000, 32'd700);
        send_item(MODE_PIN, 8'h00, 3'b100, 32'd0);
        send_item(MODE_PIN, 8'h00, 3'b000, 32'd2300);
        send_item(MODE_PIN, 8'h00, 3'b001, 32'd5000);
        send_item(MODE_PIN, 8'h00, 3'b000, 32'd5701);
        send_item(MODE_SPARE, 8'hFF, 3'b111, 32'hFFFF_FFFF);
        drain();

        configure(7'h00, 16'd0, 16'hFFFF);
        traffic(110);
        configure(7'h7F, 16'hFFFF, 16'd0);
        traffic(100);
        configure(7'($urandom_range(0, 127)), 16'($urandom_range(0, 1500)),
                  16'($urandom_range(1500, 65535)));
        traffic(110);
        configure(RST_SLAVE_ADDR, RST_PULSE_MIN, RST_PULSE_MAX);
        traffic(110);

        repeat (16) @(posedge i_clk);
        if (sb.err_count == 0)
            $display("i2c_slave_register_bank_pulse_capture_unit_test: done, clean");
        else
            $display("i2c_slave_register_bank_pulse_capture_unit_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/i2crb_pkg.sv
hw/rtl/i2crb_ram.sv
hw/rtl/i2c_slave_register_bank_pulse_capture_unit.sv
tb/sv/i2c_slave_register_bank_pulse_capture_unit_test.sv
